/* sv/asc_pkg.sv */
// ----------------------------------------------------------------------------
// asc_pkg
// Shared types, constants and coefficient table of the step counter.
// ----------------------------------------------------------------------------
package asc_pkg;

    localparam int FIR_TAPS    = 25;
    localparam int SMOOTH_TAPS = 13;
    localparam int BLOCK_LEN   = 26;

    localparam int TAP_W   = 5;
    localparam int AXIS_W  = 2;
    localparam int SIB_W   = 6;
    localparam int FFILL_W = 5;
    localparam int SFILL_W = 4;

    localparam logic [AXIS_W-1:0] LAST_AXIS = 2'd2;

    localparam logic signed [12:0] SMOOTH_GAIN = 13'sd2520;

    localparam logic signed [12:0] FIR_COEF [FIR_TAPS] = '{
        -13'sd1601, -13'sd873, -13'sd208, 13'sd392, 13'sd930, 13'sd1405,
        13'sd1817, 13'sd2165, 13'sd2450, 13'sd2672, 13'sd2830, 13'sd2925,
        13'sd2957, 13'sd2925, 13'sd2830, 13'sd2672, 13'sd2450, 13'sd2165,
        13'sd1817, 13'sd1405, 13'sd930, 13'sd392, -13'sd208, -13'sd873,
        -13'sd1601
    };

    localparam logic [15:0] MIN_GAP       = 16'd12;
    localparam logic [15:0] REARM_GAP     = 16'd6;
    localparam logic [15:0] REARM_TIMEOUT = 16'h003C;
    localparam logic signed [15:0] REARM_FALL = 16'sd4;
    localparam logic [15:0] SINCE_RESET   = 16'd46;

    localparam logic [15:0] GAP_1 = 16'h0010;
    localparam logic [15:0] GAP_2 = 16'h0014;
    localparam logic [15:0] GAP_3 = 16'h0018;
    localparam logic [15:0] GAP_4 = 16'h001E;
    localparam logic signed [15:0] RISE_0 = 16'sh005C;
    localparam logic signed [15:0] RISE_1 = 16'sh0048;
    localparam logic signed [15:0] RISE_2 = 16'sh0037;
    localparam logic signed [15:0] RISE_3 = 16'sh002A;
    localparam logic signed [15:0] RISE_4 = 16'sh0022;

    localparam logic [7:0] IDLE_INIT_RESET = 8'd99;
    localparam logic [7:0] IDLE_CONF_RESET = 8'd85;
    localparam logic [3:0] CONFIRM_RESET   = 4'd15;

    typedef enum logic [1:0] {
        REG_IDLE_INIT = 2'd0,
        REG_IDLE_CONF = 2'd1,
        REG_CONFIRM   = 2'd2,
        REG_NONE      = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_FIR,
        ST_POST,
        ST_SMOOTH,
        ST_DETECT,
        ST_BLOCK,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic              load;
        logic              fill_fir;
        logic              mac_fir;
        logic              mac_smooth;
        logic              last_tap;
        logic              post;
        logic              detect;
        logic              block;
        logic              out_load;
        logic [AXIS_W-1:0] axis;
        logic [TAP_W-1:0]  tap;
    } cmd_t;

    typedef struct packed {
        logic fir_full;
        logic smooth_full;
    } status_t;

    typedef struct packed {
        logic [7:0] idle_init;
        logic [7:0] idle_conf;
        logic [3:0] confirm;
        logic       init_wr;
        logic [7:0] init_data;
    } cfg_t;

endpackage

/* sv/asc_if.sv */
// ----------------------------------------------------------------------------
// asc_if
// Valid/ready channels for samples and results.
// ----------------------------------------------------------------------------
interface asc_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    modport source (output valid, accel_x, accel_y, accel_z, input ready);
    modport sink   (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface asc_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] shown_steps;
    logic        block_done;
    modport source (output valid, shown_steps, block_done, input ready);
    modport sink   (input valid, shown_steps, block_done, output ready);
endinterface

/* sv/asc_ctrl.sv */
// ----------------------------------------------------------------------------
// asc_ctrl
// Sequencer: steps the shared multiply-accumulate over taps and axes.
// ----------------------------------------------------------------------------
module asc_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  asc_pkg::status_t status,
    output asc_pkg::cmd_t    cmd
);
    import asc_pkg::*;

    state_t            state_reg, state_next;
    logic [AXIS_W-1:0] axis_reg, axis_next;
    logic [TAP_W-1:0]  tap_reg, tap_next;
    logic              out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            axis_reg      <= '0;
            tap_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            tap_reg       <= tap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        tap_next   = tap_reg;
        cmd        = '0;
        cmd.axis   = axis_reg;
        cmd.tap    = tap_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                axis_next = '0;
                tap_next  = '0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = status.fir_full ? ST_FIR : ST_FILL;
                end
            end
            ST_FILL:
            begin
                cmd.fill_fir = 1'b1;
                state_next   = ST_OUT;
            end
            ST_FIR:
            begin
                cmd.mac_fir  = 1'b1;
                cmd.last_tap = (tap_reg == TAP_W'(FIR_TAPS - 1));
                if (cmd.last_tap)
                begin
                    tap_next  = '0;
                    axis_next = axis_reg + 1'b1;
                    if (axis_reg == LAST_AXIS)
                        state_next = ST_POST;
                end
                else
                    tap_next = tap_reg + 1'b1;
            end
            ST_POST:
            begin
                cmd.post   = 1'b1;
                tap_next   = '0;
                state_next = status.smooth_full ? ST_SMOOTH : ST_BLOCK;
            end
            ST_SMOOTH:
            begin
                cmd.mac_smooth = 1'b1;
                cmd.last_tap   = (tap_reg == TAP_W'(SMOOTH_TAPS - 1));
                tap_next       = tap_reg + 1'b1;
                if (cmd.last_tap)
                    state_next = ST_DETECT;
            end
            ST_DETECT:
            begin
                cmd.detect = 1'b1;
                state_next = ST_BLOCK;
            end
            ST_BLOCK:
            begin
                cmd.block  = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // result register free or being drained this cycle
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

    a_tap_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mac_fir |-> tap_reg < TAP_W'(FIR_TAPS))
        else $error("fir tap index out of range");

    a_out_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> (state_reg == ST_IDLE) && out_valid_reg)
        else $error("result load did not return to idle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_FIR || state_reg == ST_FILL))
        else $error("accepted item did not start processing");

endmodule

/* sv/asc_dp.sv */
// ----------------------------------------------------------------------------
// asc_dp
// Datapath: filter histories, shared multiply-accumulate, step detector.
// ----------------------------------------------------------------------------
module asc_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  asc_pkg::cmd_t      cmd,
    input  asc_pkg::cfg_t      cfg,
    input  logic signed [15:0] accel_x,
    input  logic signed [15:0] accel_y,
    input  logic signed [15:0] accel_z,
    output asc_pkg::status_t   status,
    output logic [15:0]        shown_steps,
    output logic               block_done
);
    import asc_pkg::*;

    logic [47:0] fir_hist_reg [FIR_TAPS-1];
    logic [15:0] smooth_hist_reg [SMOOTH_TAPS-1];
    logic [47:0] sample_reg;
    logic [FFILL_W-1:0] fir_fill_reg;
    logic [SFILL_W-1:0] smooth_fill_reg;
    logic [15:0] acc_reg, level_reg;

    logic signed [15:0] prev_level_reg, rise_sum_reg, fall_sum_reg;
    logic rising_reg, armed_reg, up_reg, down_reg, pend_reg, warm_reg;
    logic [15:0] since_reg, raw_reg, last_reg, conf_reg;
    logic [3:0]  bc_reg;
    logic [7:0]  idle_reg;
    logic [SIB_W-1:0] sib_reg;
    logic done_reg;
    logic [15:0] shown_reg;
    logic        done_out_reg;

    logic signed [15:0] prev_level_next, rise_sum_next, fall_sum_next;
    logic rising_next, armed_next, up_next, down_next, pend_next, warm_next;
    logic [15:0] since_next, raw_next, last_next, conf_next;
    logic [3:0]  bc_next;
    logic [7:0]  idle_next;
    logic [SIB_W-1:0] sib_next;
    logic done_next;

    // shared multiplier
    logic [TAP_W-1:0]   tap_m1;
    logic [47:0]        fir_word;
    logic signed [15:0] op_a;
    logic signed [12:0] op_c;
    logic signed [28:0] prod;
    logic [15:0]        acc_next, acc_abs;

    assign tap_m1   = cmd.tap - 1'b1;
    assign fir_word = (cmd.tap == '0) ? sample_reg : fir_hist_reg[tap_m1];

    always_comb
    begin
        if (cmd.mac_smooth)
        begin
            op_c = SMOOTH_GAIN;
            op_a = (cmd.tap == '0) ? $signed(level_reg)
                                   : $signed(smooth_hist_reg[tap_m1[SFILL_W-1:0]]);
        end
        else
        begin
            op_c = FIR_COEF[cmd.tap];
            unique case (cmd.axis)
                2'd0:    op_a = $signed(fir_word[15:0]);
                2'd1:    op_a = $signed(fir_word[31:16]);
                default: op_a = $signed(fir_word[47:32]);
            endcase
        end
    end

    assign prod     = op_a * op_c;
    assign acc_next = acc_reg + {{3{prod[28]}}, prod[28:16]};
    assign acc_abs  = acc_next[15] ? (~acc_next + 16'd1) : acc_next;

    assign status.fir_full    = (fir_fill_reg == FFILL_W'(FIR_TAPS - 1));
    assign status.smooth_full = (smooth_fill_reg == SFILL_W'(SMOOTH_TAPS - 1));

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            sample_reg <= {accel_z, accel_y, accel_x};
        if (cmd.fill_fir || cmd.post)
        begin
            for (int i = FIR_TAPS - 2; i > 0; i--)
                fir_hist_reg[i] <= fir_hist_reg[i-1];
            fir_hist_reg[0] <= sample_reg;
        end
        if ((cmd.post && !status.smooth_full) || cmd.detect)
        begin
            for (int i = SMOOTH_TAPS - 2; i > 0; i--)
                smooth_hist_reg[i] <= smooth_hist_reg[i-1];
            smooth_hist_reg[0] <= level_reg;
        end
        if (cmd.load)
        begin
            acc_reg   <= '0;
            level_reg <= '0;
        end
        else if (cmd.mac_fir)
        begin
            acc_reg <= cmd.last_tap ? 16'd0 : acc_next;
            if (cmd.last_tap)
                level_reg <= level_reg + acc_abs;
        end
        else if (cmd.mac_smooth)
            acc_reg <= acc_next;
        if (cmd.out_load)
        begin
            shown_reg    <= conf_reg;
            done_out_reg <= done_reg;
        end
    end

    // detector, block bookkeeping and config side effects
    always_comb
    begin
        logic signed [15:0] v, pl, diff, rs, fs;
        logic [15:0] ss, raw;
        logic ris, arm, up, dn, sp, veto;
        logic [SIB_W:0] sib;

        prev_level_next = prev_level_reg;
        rise_sum_next   = rise_sum_reg;
        fall_sum_next   = fall_sum_reg;
        rising_next     = rising_reg;
        armed_next      = armed_reg;
        up_next         = up_reg;
        down_next       = down_reg;
        pend_next       = pend_reg;
        warm_next       = warm_reg;
        since_next      = since_reg;
        raw_next        = raw_reg;
        last_next       = last_reg;
        conf_next       = conf_reg;
        bc_next         = bc_reg;
        idle_next       = idle_reg;
        sib_next        = sib_reg;
        done_next       = done_reg;

        v   = $signed(acc_reg);
        pl  = warm_reg ? prev_level_reg : v;
        rs  = rise_sum_reg;
        fs  = fall_sum_reg;
        ss  = since_reg;
        raw = raw_reg;
        ris = rising_reg;
        arm = armed_reg;
        up  = up_reg;
        dn  = down_reg;
        sp  = pend_reg;
        diff = v - pl;
        if (!diff[15] && diff != 16'sd0)
            ris = 1'b1;
        else if (diff[15])
            ris = 1'b0;

        veto = (rs < RISE_0) || (ss >= GAP_1 && rs < RISE_1)
            || (ss >= GAP_2 && rs < RISE_2) || (ss >= GAP_3 && rs < RISE_3)
            || (ss >= GAP_4 && rs < RISE_4);
        if (arm && ris)
        begin
            if (ss >= MIN_GAP && !veto)
            begin
                arm = 1'b0;
                raw = raw + 16'd1;
                ss  = '0;
                rs  = '0;
                up  = 1'b0;
                sp  = 1'b1;
            end
        end
        else if (!arm)
        begin
            if ((ss >= REARM_GAP && fs >= REARM_FALL) || ss >= REARM_TIMEOUT)
            begin
                arm = 1'b1;
                fs  = '0;
                dn  = 1'b0;
            end
        end

        if (ris && arm)
            up = 1'b1;
        else if (!ris && !arm)
        begin
            dn = 1'b1;
            if (sp)
            begin
                ss = '0;
                sp = 1'b0;
                rs = '0;
            end
        end

        if (up)
            rs = v + rs - pl;
        else if (dn)
            fs = fs + pl - v;

        if (rs[15])
        begin
            rs = '0;
            up = 1'b0;
        end
        else if (fs[15])
        begin
            fs = '0;
            dn = 1'b0;
        end
        ss = ss + 16'd1;

        sib = {1'b0, sib_reg} + 1'b1;

        priority if (cmd.detect)
        begin
            prev_level_next = v;
            warm_next       = 1'b1;
            rise_sum_next   = rs;
            fall_sum_next   = fs;
            rising_next     = ris;
            armed_next      = arm;
            up_next         = up;
            down_next       = dn;
            pend_next       = sp;
            since_next      = ss;
            raw_next        = raw;
            if (last_reg == raw)
            begin
                if (ss > {8'd0, idle_reg})
                begin
                    bc_next   = '0;
                    raw_next  = conf_reg;
                    idle_next = cfg.idle_init;
                end
            end
            else
                last_next = raw;
        end
        else if (cmd.block)
        begin
            if (sib >= (SIB_W+1)'(BLOCK_LEN))
            begin
                sib_next  = '0;
                done_next = 1'b1;
                if (bc_reg >= cfg.confirm)
                begin
                    conf_next = raw_reg;
                    idle_next = cfg.idle_conf;
                end
                else
                    bc_next = bc_reg + 4'd1;
            end
            else
                sib_next = sib[SIB_W-1:0];
        end
        else if (cmd.load)
            done_next = 1'b0;
        else if (cfg.init_wr && !warm_reg)
            idle_next = cfg.init_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fir_fill_reg    <= '0;
            smooth_fill_reg <= '0;
            prev_level_reg  <= '0;
            rise_sum_reg    <= '0;
            fall_sum_reg    <= '0;
            rising_reg      <= 1'b1;
            armed_reg       <= 1'b1;
            up_reg          <= 1'b0;
            down_reg        <= 1'b0;
            pend_reg        <= 1'b0;
            warm_reg        <= 1'b0;
            since_reg       <= SINCE_RESET;
            raw_reg         <= '0;
            last_reg        <= '0;
            conf_reg        <= '0;
            bc_reg          <= '0;
            idle_reg        <= IDLE_INIT_RESET;
            sib_reg         <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            if (cmd.fill_fir)
                fir_fill_reg <= fir_fill_reg + 1'b1;
            if (cmd.post && !status.smooth_full)
                smooth_fill_reg <= smooth_fill_reg + 1'b1;
            prev_level_reg  <= prev_level_next;
            rise_sum_reg    <= rise_sum_next;
            fall_sum_reg    <= fall_sum_next;
            rising_reg      <= rising_next;
            armed_reg       <= armed_next;
            up_reg          <= up_next;
            down_reg        <= down_next;
            pend_reg        <= pend_next;
            warm_reg        <= warm_next;
            since_reg       <= since_next;
            raw_reg         <= raw_next;
            last_reg        <= last_next;
            conf_reg        <= conf_next;
            bc_reg          <= bc_next;
            idle_reg        <= idle_next;
            sib_reg         <= sib_next;
            done_reg        <= done_next;
        end
    end

    assign shown_steps = shown_reg;
    assign block_done  = done_out_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fir_fill_reg <= FFILL_W'(FIR_TAPS - 1))
        else $error("fir fill count overran");

    a_block_len: assert property (@(posedge clk) disable iff (!rst_n)
        sib_reg < SIB_W'(BLOCK_LEN))
        else $error("sample in block overran");

    a_step_resets_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.detect && raw_next == raw_reg + 16'd1 && last_reg != raw_reg + 16'd1)
        |=> since_reg == 16'd1)
        ;

endmodule

/* sv/accel_step_counter.sv */
// ----------------------------------------------------------------------------
// accel_step_counter
// Three-axis accelerometer step counter with APB configuration.
// ----------------------------------------------------------------------------
// sequencing: while the fir history fills a sample only shifts into it; else
//   the fir runs 75 taps, plus 13 smoothing taps once that history is full
// throughput: set by the single shared multiply-accumulate unit stepping through
//   all taps; a new sample is taken only after the previous result is loaded
// reset: asynchronous active low; clears control state and loads register
//   reset values, filter histories stay undefined until filled
module accel_step_counter (
    input  logic               clk,
    input  logic               rst_n,
    asc_sample_if.sink         sample,
    asc_result_if.source       result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import asc_pkg::*;

    cmd_t     cmd;
    status_t  status;
    cfg_t     cfg;
    reg_idx_t idx;
    logic     wr;
    logic [7:0] idle_init_reg, idle_conf_reg;
    logic [3:0] confirm_reg;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_init_reg <= IDLE_INIT_RESET;
            idle_conf_reg <= IDLE_CONF_RESET;
            confirm_reg   <= CONFIRM_RESET;
        end
        else if (wr)
        begin
            unique case (idx)
                REG_IDLE_INIT: idle_init_reg <= pwdata[7:0];
                REG_IDLE_CONF: idle_conf_reg <= pwdata[7:0];
                REG_CONFIRM:   confirm_reg   <= pwdata[3:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_IDLE_INIT: prdata = {24'd0, idle_init_reg};
            REG_IDLE_CONF: prdata = {24'd0, idle_conf_reg};
            REG_CONFIRM:   prdata = {28'd0, confirm_reg};
            default:       prdata = '0;
        endcase
    end

    assign cfg.idle_init = idle_init_reg;
    assign cfg.idle_conf = idle_conf_reg;
    assign cfg.confirm   = confirm_reg;
    assign cfg.init_wr   = wr && (idx == REG_IDLE_INIT);
    assign cfg.init_data = pwdata[7:0];

    asc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_ready  (sample.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    asc_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg         (cfg),
        .accel_x     (sample.accel_x),
        .accel_y     (sample.accel_y),
        .accel_z     (sample.accel_z),
        .status      (status),
        .shown_steps (result.shown_steps),
        .block_done  (result.block_done)
    );

endmodule
